FILE: design/bcd_countdown_timer_with_alarm_top_defines.svh
// Assertion macros for the BCD countdown timer block.
// Included by the top level; no other dependencies.
`ifndef BCD_COUNTDOWN_TIMER_WITH_ALARM_TOP_DEFINES_SVH
`define BCD_COUNTDOWN_TIMER_WITH_ALARM_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset
`define BCDT_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bcdt assertion failed");

// Check that a condition implies another in the next cycle
`define BCDT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcdt assertion failed");

`else

`define BCDT_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define BCDT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: design/bcdt_pkg.sv
// Shared types, codes and helpers for the BCD countdown timer.
// No dependencies; used by the channel interfaces and the top level.
package bcdt_pkg;

   // Field widths
   localparam int OPCODE_W    = 2;
   localparam int SECONDS_W   = 13;
   localparam int DIGIT_W     = 4;
   localparam int SEC_TENS_W  = 3;
   localparam int BLINK_W     = 4;
   localparam int STEP_W      = 5;
   localparam int MINUTES_W   = 7;
   localparam int REMAIN_W    = 6;

   // Configuration port
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLINK_ADDR = 2'd0;
   localparam logic [BLINK_W-1:0]    BLINK_RESET    = 4'd3;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_STOP  = 2'd2;

   // Start-time conversion: clamp, then divide by 60 through a reciprocal
   localparam logic [SECONDS_W-1:0] MAX_SECONDS = 13'd5999;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 15;
   localparam logic [RECIP_W-1:0] RECIP_60 = 15'd17477;  // ceil(2^20 / 60)
   localparam int PROD_W      = SECONDS_W + RECIP_W;

   // Digit reload values on borrow
   localparam logic [DIGIT_W-1:0]    DIGIT_MAX    = 4'd9;
   localparam logic [SEC_TENS_W-1:0] SEC_TENS_MAX = 3'd5;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_COUNT = 2'd1,
      PH_ALARM = 2'd2
   } phase_type;

   typedef struct packed {
      logic [DIGIT_W-1:0]    min_tens;
      logic [DIGIT_W-1:0]    min_units;
      logic [SEC_TENS_W-1:0] sec_tens;
      logic [DIGIT_W-1:0]    sec_units;
   } time_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] units;
   } bcd_pair_type;

   typedef struct packed {
      logic [DIGIT_W-1:0]    minutes_tens;
      logic [DIGIT_W-1:0]    minutes_units;
      logic [SEC_TENS_W-1:0] seconds_tens;
      logic [DIGIT_W-1:0]    seconds_units;
      logic                  show_end;
      logic                  lamps_on;
      logic                  buzzer_on;
      logic                  busy_res;
   } result_type;

   // Split a value below 100 into two BCD digits; tens = (v * 205) >> 11
   function automatic bcd_pair_type bcd_split(input logic [MINUTES_W-1:0] v);
      logic [14:0]          prod;
      logic [MINUTES_W-1:0] tens_x10;
      logic [MINUTES_W-1:0] units_wide;
      bcd_pair_type         pair;
      prod       = 15'(v) * 15'd205;
      pair.tens  = prod[14:11];
      tens_x10   = {pair.tens[3:0], 3'b000} - 7'd0 + {2'b00, pair.tens, 1'b0};
      units_wide = v - tens_x10;
      pair.units = units_wide[DIGIT_W-1:0];
      return pair;
   endfunction

endpackage

FILE: design/bcdt_req_if.sv
// Input channel of the BCD countdown timer: valid/ready with opcode and start time.
// Depends on bcdt_pkg for field widths.
interface bcdt_req_if;
   import bcdt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [SECONDS_W-1:0]  start_seconds;

   modport source (output valid, output opcode, output start_seconds, input ready);
   modport sink   (input valid, input opcode, input start_seconds, output ready);
endinterface

FILE: design/bcdt_rsp_if.sv
// Result channel of the BCD countdown timer: valid/ready with display and lamp state.
// Depends on bcdt_pkg for field widths.
interface bcdt_rsp_if;
   import bcdt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [DIGIT_W-1:0]     minutes_tens;
   logic [DIGIT_W-1:0]     minutes_units;
   logic [SEC_TENS_W-1:0]  seconds_tens;
   logic [DIGIT_W-1:0]     seconds_units;
   logic                   show_end;
   logic                   lamps_on;
   logic                   buzzer_on;
   logic                   busy_res;

   modport source (output valid, output minutes_tens, output minutes_units,
                   output seconds_tens, output seconds_units, output show_end,
                   output lamps_on, output buzzer_on, output busy_res, input ready);
   modport sink   (input valid, input minutes_tens, input minutes_units,
                   input seconds_tens, input seconds_units, input show_end,
                   input lamps_on, input buzzer_on, input busy_res, output ready);
endinterface

FILE: design/bcd_countdown_timer_with_alarm_top.sv
// BCD countdown timer (MM:SS) with alarm. Every accepted item gives exactly one
// result item, the display and lamp state after that item, offered on the result
// channel by the result register; one item is taken per cycle while results are
// read. The logic in front of the input register clamps the start time and splits
// it into minutes and seconds with a reciprocal multiply; the second stage updates
// the phase, digits and blink step and loads the result register. The result
// register parts the channels, so a stalled result only holds the input stage, and
// an item is taken whenever that stage is free or moving on in the same cycle.
// blink_count sits at CSR byte address 0 (reset 3); pready is always high.
// Depends on bcdt_pkg, bcdt_req_if, bcdt_rsp_if and the defines header.
`include "bcd_countdown_timer_with_alarm_top_defines.svh"

module bcd_countdown_timer_with_alarm_top (
   input  logic                            clock,
   input  logic                            reset,
   bcdt_req_if.sink                        req_bus,
   bcdt_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bcdt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bcdt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bcdt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import bcdt_pkg::*;

   logic [BLINK_W-1:0]     blink_ff;
   logic                   csr_write;

   logic                   s1_valid_ff;
   logic [OPCODE_W-1:0]    s1_op_ff;
   logic [MINUTES_W-1:0]   s1_min_ff;
   logic [REMAIN_W-1:0]    s1_rem_ff;

   logic [SECONDS_W-1:0]   secs_clamp;
   logic [PROD_W-1:0]      recip_prod;
   logic [MINUTES_W-1:0]   minutes;
   logic [SECONDS_W-1:0]   min_x60;
   logic [SECONDS_W-1:0]   rem_wide;

   logic                   req_take;
   logic                   advance;

   phase_type              phase_ff, phase_in;
   time_type               digits_ff, digits_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [STEP_W:0]        step_next;
   bcd_pair_type           min_pair, sec_pair;

   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, result_in;

   // Configuration port: one register, writes complete in the access cycle
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_BLINK_ADDR);
   assign csr_prdata = (csr_paddr == CSR_BLINK_ADDR)
                       ? {{(CSR_DATA_W-BLINK_W){1'b0}}, blink_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ff <= BLINK_RESET;
      end else if (csr_write) begin
         blink_ff <= csr_pwdata[BLINK_W-1:0];
      end
   end

   // Handshake: the input stage moves on when the result register is free or being read
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   // Clamp the start time and split it into minutes and remaining seconds
   assign secs_clamp = (req_bus.start_seconds > MAX_SECONDS)
                       ? MAX_SECONDS : req_bus.start_seconds;
   assign recip_prod = PROD_W'(secs_clamp) * PROD_W'(RECIP_60);
   assign minutes    = recip_prod[RECIP_SHIFT +: MINUTES_W];
   assign min_x60    = {minutes, 6'b000000} - {4'b0000, minutes, 2'b00};
   assign rem_wide   = secs_clamp - min_x60;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff  <= req_bus.opcode;
         s1_min_ff <= minutes;
         s1_rem_ff <= rem_wide[REMAIN_W-1:0];
      end
   end

   // Split minutes and seconds into BCD digits
   assign min_pair = bcd_split(s1_min_ff);
   assign sec_pair = bcd_split({1'b0, s1_rem_ff});

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         digits_ff <= '0;
         step_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         step_ff   <= step_in;
      end
   end

   // Next state: start, tick or stop applied to the current phase
   always_comb begin
      phase_in  = phase_ff;
      digits_in = digits_ff;
      step_in   = step_ff;
      step_next = {1'b0, step_ff} + 6'd1;
      if (advance) begin
         unique case (s1_op_ff)
            OP_START: begin
               phase_in            = PH_COUNT;
               digits_in.min_tens  = min_pair.tens;
               digits_in.min_units = min_pair.units;
               digits_in.sec_tens  = sec_pair.tens[SEC_TENS_W-1:0];
               digits_in.sec_units = sec_pair.units;
               step_in             = '0;
            end
            OP_TICK: begin
               unique case (phase_ff)
                  PH_COUNT: begin
                     // Count down with borrow; a tick at 00:00 ends the count
                     priority if (digits_ff.sec_units != '0) begin
                        digits_in.sec_units = digits_ff.sec_units - 4'd1;
                     end else if (digits_ff.sec_tens != '0) begin
                        digits_in.sec_tens  = digits_ff.sec_tens - 3'd1;
                        digits_in.sec_units = DIGIT_MAX;
                     end else if (digits_ff.min_units != '0) begin
                        digits_in.min_units = digits_ff.min_units - 4'd1;
                        digits_in.sec_tens  = SEC_TENS_MAX;
                        digits_in.sec_units = DIGIT_MAX;
                     end else if (digits_ff.min_tens != '0) begin
                        digits_in.min_tens  = digits_ff.min_tens - 4'd1;
                        digits_in.min_units = DIGIT_MAX;
                        digits_in.sec_tens  = SEC_TENS_MAX;
                        digits_in.sec_units = DIGIT_MAX;
                     end else begin
                        digits_in = '0;
                        step_in   = '0;
                        phase_in  = (blink_ff == '0) ? PH_IDLE : PH_ALARM;
                     end
                  end
                  PH_ALARM: begin
                     // Advance the blink step; drop to idle when all blinks are done
                     if (step_next >= {1'b0, blink_ff, 1'b0}) begin
                        phase_in  = PH_IDLE;
                        digits_in = '0;
                        step_in   = '0;
                     end else begin
                        step_in = step_next[STEP_W-1:0];
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            OP_STOP: begin
               phase_in  = PH_IDLE;
               digits_in = '0;
               step_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Result from the state after the item
   always_comb begin
      result_in               = '0;
      if (phase_in == PH_COUNT) begin
         result_in.minutes_tens  = digits_in.min_tens;
         result_in.minutes_units = digits_in.min_units;
         result_in.seconds_tens  = digits_in.sec_tens;
         result_in.seconds_units = digits_in.sec_units;
         result_in.lamps_on      = 1'b1;
         result_in.busy_res      = 1'b1;
      end else if (phase_in == PH_ALARM) begin
         result_in.show_end      = 1'b1;
         result_in.buzzer_on     = 1'b1;
         result_in.lamps_on      = step_in[0];
         result_in.busy_res      = 1'b1;
      end
   end

   // Result register
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.minutes_tens  = rsp_ff.minutes_tens;
   assign rsp_bus.minutes_units = rsp_ff.minutes_units;
   assign rsp_bus.seconds_tens  = rsp_ff.seconds_tens;
   assign rsp_bus.seconds_units = rsp_ff.seconds_units;
   assign rsp_bus.show_end      = rsp_ff.show_end;
   assign rsp_bus.lamps_on      = rsp_ff.lamps_on;
   assign rsp_bus.buzzer_on     = rsp_ff.buzzer_on;
   assign rsp_bus.busy_res      = rsp_ff.busy_res;

   // Displayed digits stay in BCD range
   `BCDT_ASSERT_ALWAYS(a_digit_range, clock, reset, !rsp_valid_ff || (rsp_ff.seconds_tens <= SEC_TENS_MAX && rsp_ff.seconds_units <= DIGIT_MAX && rsp_ff.minutes_units <= DIGIT_MAX && rsp_ff.minutes_tens <= DIGIT_MAX))
   // The alarm display blanks the outer digits, sounds the buzzer and reports busy
   `BCDT_ASSERT_ALWAYS(a_alarm_outputs, clock, reset, !rsp_valid_ff || !rsp_ff.show_end || (rsp_ff.buzzer_on && rsp_ff.busy_res && rsp_ff.minutes_tens == '0 && rsp_ff.seconds_units == '0))
   // A stop item always reports idle
   `BCDT_ASSERT_NEXT(a_stop_idle, clock, reset, advance && s1_op_ff == OP_STOP, rsp_valid_ff && !rsp_ff.busy_res && phase_ff == PH_IDLE)
   // An empty input stage never refuses an item
   `BCDT_ASSERT_ALWAYS(a_ready_when_empty, clock, reset, s1_valid_ff || req_bus.ready)

endmodule
